>>> hdl/lup_pkg.sv
// shared types, constants and helpers for the lens undistortion point block
`default_nettype none
package lup_pkg;

  localparam int unsigned MAX_ITERATIONS = 20;
  localparam int unsigned TOLERANCE_LSB  = 1074;
  localparam int unsigned ITER_W         = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned NUM_W          = 55;
  localparam int unsigned DCNT_W         = $clog2(NUM_W);

  localparam logic signed [39:0] Q30_ONE = 40'sd1073741824;
  localparam logic signed [39:0] OUT_MAX = 40'sd2097151;
  localparam logic signed [39:0] OUT_MIN = -40'sd2097152;
  localparam logic signed [39:0] TOL_POS = 40'(TOLERANCE_LSB);
  localparam logic signed [39:0] TOL_NEG = -40'(TOLERANCE_LSB);

  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER   = 3'd2;
  localparam logic [2:0] REG_K1       = 3'd3;
  localparam logic [2:0] REG_K2       = 3'd4;
  localparam logic [2:0] REG_K3       = 3'd5;
  localparam logic [2:0] REG_P1       = 3'd6;
  localparam logic [2:0] REG_P2       = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_OUT
  } state_e;

  typedef enum logic [4:0] {
    SP_XX, SP_YY, SP_XY, SP_R4, SP_R6, SP_K1, SP_K2, SP_K3,
    SP_RX, SP_P2X, SP_P1X, SP_RY, SP_P1Y, SP_P2Y, SP_UPD, SP_OUTU, SP_OUTV
  } step_e;

  typedef enum logic [1:0] {
    SH_28,
    SH_30,
    SH_34
  } shift_e;

  function automatic logic signed [39:0] sx40(input logic signed [31:0] v);
    return {{8{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat30(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > $signed(40'h007FFFFFFF)) begin
      r = 32'h7FFFFFFF;
    end else if (v < $signed(40'hFF80000000)) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/lens_undistort_point.sv
// iterative brown-conrady undistortion of one pixel point on a shared multiplier
// When all coefficients are zero a point passes straight through; otherwise two
// restoring divisions (one quotient bit per cycle) normalize the point, then each
// iteration runs 15 sequencer steps on the single 32x32 multiplier, for up to 20
// iterations, and two more multiplier steps map the point back to pixels. The
// block takes no new point until its result transaction completes.
`default_nettype none
module lens_undistort_point (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [19:0] pixel_u_i,
  input  wire logic [19:0] pixel_v_i,
  input  wire logic        batch_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [21:0] undist_u_o,
  output logic signed [21:0] undist_v_o,
  output logic             clipped_o,
  output logic             batch_end_out_o
);
  import lup_pkg::*;

  logic [23:0] focal_x_q, focal_y_q;
  logic [39:0] center_q;
  logic signed [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;

  state_e state_q, state_d;
  step_e  step_q;
  logic   ph_q;
  logic [ITER_W-1:0] iter_q;

  logic [NUM_W-1:0]  num_q;
  logic [23:0]       rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic              dsel_q, dneg_q;
  logic [19:0]       pv_q;

  logic signed [31:0] x_q, y_q, xo_q, yo_q, xx_q, yy_q, xy_q, r2_q, r4_q, r6_q;
  logic signed [31:0] rad_q, dx_q, dy_q;
  logic signed [39:0] acc_q;

  logic [63:0] p_q;
  logic        mneg_q;
  shift_e      sh_q;

  logic signed [21:0] ou_q, ov_q;
  logic               clip_q, be_q;

  logic [19:0] cx, cy;
  logic        coef_zero;
  logic        cfg_wr;

  assign cx = center_q[19:0];
  assign cy = center_q[39:20];
  assign coef_zero = (k1_q == '0) && (k2_q == '0) && (k3_q == '0) &&
                     (p1_q == '0) && (p2_q == '0);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q <= 24'd256;
      focal_y_q <= 24'd256;
      center_q  <= '0;
      k1_q <= '0;
      k2_q <= '0;
      k3_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_FOCAL_X: focal_x_q <= pwdata[23:0];
        REG_FOCAL_Y: focal_y_q <= pwdata[23:0];
        REG_CENTER:  center_q  <= pwdata[39:0];
        REG_K1:      k1_q <= pwdata[31:0];
        REG_K2:      k2_q <= pwdata[31:0];
        REG_K3:      k3_q <= pwdata[31:0];
        REG_P1:      p1_q <= pwdata[31:0];
        REG_P2:      p2_q <= pwdata[31:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_FOCAL_X: prdata = {40'd0, focal_x_q};
      REG_FOCAL_Y: prdata = {40'd0, focal_y_q};
      REG_CENTER:  prdata = {24'd0, center_q};
      REG_K1:      prdata = {32'd0, k1_q};
      REG_K2:      prdata = {32'd0, k2_q};
      REG_K3:      prdata = {32'd0, k3_q};
      REG_P1:      prdata = {32'd0, p1_q};
      REG_P2:      prdata = {32'd0, p2_q};
      default:     prdata = '0;
    endcase
  end

  // divider: restoring, one quotient bit per cycle
  logic [23:0] fd;
  logic [24:0] dt;
  logic        dge;
  logic [23:0] rem_d;
  logic [NUM_W-1:0] qfin;
  logic [31:0] qsat;
  logic signed [39:0] qsig;
  logic signed [31:0] qres;
  logic        div_last;

  assign fd    = dsel_q ? ((focal_y_q == '0) ? 24'd1 : focal_y_q)
                        : ((focal_x_q == '0) ? 24'd1 : focal_x_q);
  assign dt    = {rem_q, num_q[NUM_W-1]};
  assign dge   = dt >= {1'b0, fd};
  assign rem_d = dge ? 24'(dt - {1'b0, fd}) : dt[23:0];
  assign qfin  = {num_q[NUM_W-2:0], dge};
  assign qsat  = (qfin > 55'h80000000) ? 32'h80000000 : qfin[31:0];
  assign qsig  = dneg_q ? -$signed({8'd0, qsat}) : $signed({8'd0, qsat});
  assign qres  = sat30(qsig);
  assign div_last = (dcnt_q == DCNT_W'(NUM_W - 1));

  // dividend load for either coordinate
  logic [19:0] ld_p, ld_c;
  logic [23:0] ld_f;
  logic signed [20:0] ld_diff;
  logic [19:0] ld_mag;
  logic [NUM_W-1:0] ld_num;

  always_comb begin
    if (state_q == ST_IDLE) begin
      ld_p = pixel_u_i;
      ld_c = cx;
      ld_f = (focal_x_q == '0) ? 24'd1 : focal_x_q;
    end else begin
      ld_p = pv_q;
      ld_c = cy;
      ld_f = (focal_y_q == '0) ? 24'd1 : focal_y_q;
    end
    ld_diff = $signed({1'b0, ld_p}) - $signed({1'b0, ld_c});
    ld_mag  = ld_diff[20] ? 20'(-ld_diff) : ld_diff[19:0];
    ld_num  = {1'b0, ld_mag, 34'd0} + NUM_W'(ld_f >> 1);
  end

  // multiplier operand selection
  logic signed [32:0] ma, mb;
  shift_e msh;
  logic [31:0] amag, bmag;

  always_comb begin
    ma  = '0;
    mb  = '0;
    msh = SH_30;
    unique case (step_q)
      SP_XX:   begin ma = {x_q[31], x_q};   mb = {x_q[31], x_q}; end
      SP_YY:   begin ma = {y_q[31], y_q};   mb = {y_q[31], y_q}; end
      SP_XY:   begin ma = {x_q[31], x_q};   mb = {y_q[31], y_q}; end
      SP_R4:   begin ma = {r2_q[31], r2_q}; mb = {r2_q[31], r2_q}; end
      SP_R6:   begin ma = {r4_q[31], r4_q}; mb = {r2_q[31], r2_q}; end
      SP_K1:   begin ma = {k1_q[31], k1_q}; mb = {r2_q[31], r2_q}; msh = SH_28; end
      SP_K2:   begin ma = {k2_q[31], k2_q}; mb = {r4_q[31], r4_q}; msh = SH_28; end
      SP_K3:   begin ma = {k3_q[31], k3_q}; mb = {r6_q[31], r6_q}; msh = SH_28; end
      SP_RX:   begin ma = {rad_q[31], rad_q}; mb = {x_q[31], x_q}; end
      SP_P2X:  begin ma = {p2_q[31], p2_q}; mb = {xy_q[31], xy_q}; msh = SH_28; end
      SP_P1X:  begin
        ma  = {p1_q[31], p1_q};
        mb  = 33'(sx40(sat30(sx40(r2_q) + (sx40(xx_q) <<< 1))));
        msh = SH_28;
      end
      SP_RY:   begin ma = {rad_q[31], rad_q}; mb = {y_q[31], y_q}; end
      SP_P1Y:  begin ma = {p1_q[31], p1_q}; mb = {xy_q[31], xy_q}; msh = SH_28; end
      SP_P2Y:  begin
        ma  = {p2_q[31], p2_q};
        mb  = 33'(sx40(sat30(sx40(r2_q) + (sx40(yy_q) <<< 1))));
        msh = SH_28;
      end
      SP_UPD:  ;
      SP_OUTU: begin ma = {9'd0, focal_x_q}; mb = {x_q[31], x_q}; msh = SH_34; end
      SP_OUTV: begin ma = {9'd0, focal_y_q}; mb = {y_q[31], y_q}; msh = SH_34; end
      default: ;
    endcase
    amag = ma[32] ? 32'(-ma) : ma[31:0];
    bmag = mb[32] ? 32'(-mb) : mb[31:0];
  end

  // rounding, sign and saturation of the registered product
  logic [64:0] rsum;
  logic [36:0] rmag;
  logic signed [39:0] res, rs;

  always_comb begin
    unique case (sh_q)
      SH_28:   rsum = {1'b0, p_q} + (65'd1 << 27);
      SH_30:   rsum = {1'b0, p_q} + (65'd1 << 29);
      SH_34:   rsum = {1'b0, p_q} + (65'd1 << 33);
      default: rsum = {1'b0, p_q};
    endcase
    unique case (sh_q)
      SH_28:   rmag = rsum[64:28];
      SH_30:   rmag = {2'd0, rsum[64:30]};
      SH_34:   rmag = {6'd0, rsum[64:34]};
      default: rmag = '0;
    endcase
    res = mneg_q ? -$signed({3'd0, rmag}) : $signed({3'd0, rmag});
    rs  = sx40(sat30(res));
  end

  logic signed [39:0] pix_sum;
  logic signed [21:0] pix_sat;
  logic               pix_clip;
  logic               conv;

  always_comb begin
    pix_sum = res + $signed({20'd0, (step_q == SP_OUTU) ? cx : cy});
    if (pix_sum > OUT_MAX) begin
      pix_sat = 22'(OUT_MAX);
      pix_clip = 1'b1;
    end else if (pix_sum < OUT_MIN) begin
      pix_sat = 22'(OUT_MIN);
      pix_clip = 1'b1;
    end else begin
      pix_sat = pix_sum[21:0];
      pix_clip = 1'b0;
    end
    conv = (sx40(dx_q) < TOL_POS) && (sx40(dx_q) > TOL_NEG) &&
           (sx40(dy_q) < TOL_POS) && (sx40(dy_q) > TOL_NEG);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        state_d = coef_zero ? ST_OUT : ST_DIV;
      end
      ST_DIV:  if (div_last && dsel_q) begin
        state_d = ST_CALC;
      end
      ST_CALC: if (step_q == SP_OUTV && ph_q) begin
        state_d = ST_OUT;
      end
      ST_OUT:  if (out_ready_i) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
  end

  assign undist_u_o      = ou_q;
  assign undist_v_o      = ov_q;
  assign clipped_o       = clip_q;
  assign batch_end_out_o = be_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= SP_XX;
      ph_q    <= 1'b0;
      iter_q  <= '0;
      dcnt_q  <= '0;
      dsel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          dcnt_q <= '0;
          dsel_q <= 1'b0;
          step_q <= SP_XX;
          ph_q   <= 1'b0;
          iter_q <= '0;
        end
        ST_DIV: begin
          dcnt_q <= div_last ? '0 : dcnt_q + 1'b1;
          if (div_last) begin
            dsel_q <= 1'b1;
          end
        end
        ST_CALC: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (step_q == SP_UPD) begin
              if (conv || iter_q == ITER_W'(MAX_ITERATIONS - 1)) begin
                step_q <= SP_OUTU;
              end else begin
                step_q <= SP_XX;
                iter_q <= iter_q + 1'b1;
              end
            end else if (step_q != SP_OUTV) begin
              step_q <= step_e'(step_q + 5'd1);
            end
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        be_q   <= batch_end_i;
        pv_q   <= pixel_v_i;
        num_q  <= ld_num;
        rem_q  <= '0;
        dneg_q <= ld_diff[20];
        if (coef_zero) begin
          ou_q   <= {2'd0, pixel_u_i};
          ov_q   <= {2'd0, pixel_v_i};
          clip_q <= 1'b0;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          if (dsel_q) begin
            yo_q <= qres;
            y_q  <= qres;
          end else begin
            xo_q   <= qres;
            x_q    <= qres;
            num_q  <= ld_num;
            rem_q  <= '0;
            dneg_q <= ld_diff[20];
          end
        end else begin
          num_q <= qfin;
          rem_q <= rem_d;
        end
        clip_q <= 1'b0;
      end
      ST_CALC: begin
        if (!ph_q) begin
          p_q    <= amag * bmag;
          mneg_q <= ma[32] ^ mb[32];
          sh_q   <= msh;
        end else begin
          unique case (step_q)
            SP_XX:   xx_q <= rs[31:0];
            SP_YY:   begin
              yy_q <= rs[31:0];
              r2_q <= sat30(sx40(xx_q) + rs);
            end
            SP_XY:   xy_q <= rs[31:0];
            SP_R4:   r4_q <= rs[31:0];
            SP_R6:   r6_q <= rs[31:0];
            SP_K1:   acc_q <= Q30_ONE + rs;
            SP_K2:   acc_q <= acc_q + rs;
            SP_K3:   rad_q <= sat30(acc_q + rs);
            SP_RX:   acc_q <= rs;
            SP_P2X:  acc_q <= acc_q + (rs <<< 1);
            SP_P1X:  dx_q <= sat30(sx40(sat30(acc_q + rs)) - sx40(xo_q));
            SP_RY:   begin
              acc_q <= rs;
              x_q   <= sat30(sx40(x_q) - sx40(dx_q));
            end
            SP_P1Y:  acc_q <= acc_q + (rs <<< 1);
            SP_P2Y:  dy_q <= sat30(sx40(sat30(acc_q + rs)) - sx40(yo_q));
            SP_UPD:  y_q <= sat30(sx40(y_q) - sx40(dy_q));
            SP_OUTU: begin
              ou_q   <= pix_sat;
              clip_q <= clip_q | pix_clip;
            end
            SP_OUTV: begin
              ov_q   <= pix_sat;
              clip_q <= clip_q | pix_clip;
            end
            default: ;
          endcase
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> bench/lens_undistort_point_tb.sv
// self-checking testbench for lens_undistort_point with a scoreboard class
`default_nettype none
module lens_undistort_point_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lup_pkg::*;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint Q30_HI = 64'sd2147483647;
  localparam longint Q30_LO = -64'sd2147483648;

  typedef struct {
    logic signed [21:0] u;
    logic signed [21:0] v;
    logic               clip;
    logic               be;
  } undist_res_t;

  class undist_scoreboard;
    longint focal_x, focal_y, cx, cy;
    longint k1, k2, k3, p1, p2;
    undist_res_t expected_q[$];
    int errors;

    function new();
      focal_x = 256;
      focal_y = 256;
      cx = 0;
      cy = 0;
      k1 = 0; k2 = 0; k3 = 0; p1 = 0; p2 = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_FOCAL_X: focal_x = longint'(val[23:0]);
        REG_FOCAL_Y: focal_y = longint'(val[23:0]);
        REG_CENTER: begin
          cx = longint'(val[19:0]);
          cy = longint'(val[39:20]);
        end
        REG_K1: k1 = longint'($signed(val[31:0]));
        REG_K2: k2 = longint'($signed(val[31:0]));
        REG_K3: k3 = longint'($signed(val[31:0]));
        REG_P1: p1 = longint'($signed(val[31:0]));
        REG_P2: p2 = longint'($signed(val[31:0]));
        default: ;
      endcase
    endfunction

    function longint clamp_q30(longint x);
      if (x > Q30_HI) return Q30_HI;
      if (x < Q30_LO) return Q30_LO;
      return x;
    endfunction

    // product rounded half away from zero
    function longint mul_round(longint a, longint b, int sh);
      bit neg;
      longint unsigned ma, mb, m;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb + (64'd1 << (sh - 1))) >> sh;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint mul_q30(longint a, longint b);
      return clamp_q30(mul_round(a, b, 30));
    endfunction

    function longint mul_coef(longint k, longint b);
      return clamp_q30(mul_round(k, b, 28));
    endfunction

    function longint to_norm(longint diff, longint f);
      longint unsigned fd, mag, q;
      longint r;
      fd = (f == 0) ? 1 : f;
      mag = (diff < 0) ? -diff : diff;
      q = ((mag << 34) + fd / 2) / fd;
      r = (q > 64'd2147483648) ? 64'sd2147483648 : longint'(q);
      return clamp_q30((diff < 0) ? -r : r);
    endfunction

    function longint to_pix(longint x, longint f, longint c, inout bit clip);
      longint y;
      y = mul_round(f, x, 34) + c;
      if (y > 2097151) begin
        clip = 1;
        return 2097151;
      end
      if (y < -2097152) begin
        clip = 1;
        return -2097152;
      end
      return y;
    endfunction

    function void note_point(logic [19:0] pu, logic [19:0] pv, logic be);
      undist_res_t r;
      longint ou, ov, xo, yo, x, y, xx, yy, xy, r2, r4, r6, rad, xd, yd, dx, dy;
      bit clip;
      clip = 0;
      if (k1 == 0 && k2 == 0 && k3 == 0 && p1 == 0 && p2 == 0) begin
        ou = longint'(pu);
        ov = longint'(pv);
      end else begin
        xo = to_norm(longint'(pu) - cx, focal_x);
        yo = to_norm(longint'(pv) - cy, focal_y);
        x = xo;
        y = yo;
        for (int i = 0; i < MAX_ITERATIONS; i++) begin
          xx = mul_q30(x, x);
          yy = mul_q30(y, y);
          xy = mul_q30(x, y);
          r2 = clamp_q30(xx + yy);
          r4 = mul_q30(r2, r2);
          r6 = mul_q30(r4, r2);
          rad = clamp_q30(64'sd1073741824 + mul_coef(k1, r2) + mul_coef(k2, r4)
                          + mul_coef(k3, r6));
          xd = clamp_q30(mul_q30(rad, x) + 2 * mul_coef(p2, xy)
                         + mul_coef(p1, clamp_q30(r2 + 2 * xx)));
          yd = clamp_q30(mul_q30(rad, y) + 2 * mul_coef(p1, xy)
                         + mul_coef(p2, clamp_q30(r2 + 2 * yy)));
          dx = clamp_q30(xd - xo);
          dy = clamp_q30(yd - yo);
          x = clamp_q30(x - dx);
          y = clamp_q30(y - dy);
          if (dx < longint'(TOLERANCE_LSB) && dx > -longint'(TOLERANCE_LSB) &&
              dy < longint'(TOLERANCE_LSB) && dy > -longint'(TOLERANCE_LSB)) break;
        end
        ou = to_pix(x, focal_x, cx, clip);
        ov = to_pix(y, focal_y, cy, clip);
      end
      r.u = ou[21:0];
      r.v = ov[21:0];
      r.clip = clip;
      r.be = be;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic signed [21:0] u, logic signed [21:0] v, logic clip, logic be);
      undist_res_t e;
      if (expected_q.size() == 0) begin
        report("result transaction with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (u !== e.u) report($sformatf("undist_u %0d, expected %0d", u, e.u));
      if (v !== e.v) report($sformatf("undist_v %0d, expected %0d", v, e.v));
      if (clip !== e.clip) report($sformatf("clipped %0b, expected %0b", clip, e.clip));
      if (be !== e.be) report($sformatf("batch_end_out %0b, expected %0b", be, e.be));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [19:0] pixel_u_i = '0;
  logic [19:0] pixel_v_i = '0;
  logic batch_end_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [21:0] undist_u_o;
  logic signed [21:0] undist_v_o;
  logic clipped_o;
  logic batch_end_out_o;

  undist_scoreboard sb = new();
  bit idle_on = 1'b1;
  longint cycles = 0;

  lens_undistort_point u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_u_i      (pixel_u_i),
    .pixel_v_i      (pixel_v_i),
    .batch_end_i    (batch_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .undist_u_o     (undist_u_o),
    .undist_v_o     (undist_v_o),
    .clipped_o      (clipped_o),
    .batch_end_out_o(batch_end_out_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lens_undistort_point_tb: errors");
      $finish;
    end
  end

  // transaction monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_point(pixel_u_i, pixel_v_i, batch_end_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(undist_u_o, undist_v_o, clipped_o, batch_end_out_o);
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= idle_on ? ($urandom_range(0, 99) >= 8) : 1'b1;
  end

  task write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task wait_drained();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task send_point(logic [19:0] pu, logic [19:0] pv, logic be);
    if (idle_on && $urandom_range(0, 99) < 8) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    in_valid_i = 1'b1;
    pixel_u_i = pu;
    pixel_v_i = pv;
    batch_end_i = be;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task set_lens(logic [63:0] fx, logic [63:0] fy, logic [63:0] ctr,
                logic [31:0] c1, logic [31:0] c2, logic [31:0] c3,
                logic [31:0] t1, logic [31:0] t2);
    wait_drained();
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER, ctr);
    write_reg(REG_K1, {32'b0, c1});
    write_reg(REG_K2, {32'b0, c2});
    write_reg(REG_K3, {32'b0, c3});
    write_reg(REG_P1, {32'b0, t1});
    write_reg(REG_P2, {32'b0, t2});
  endtask

  function automatic logic [31:0] small_coef();
    return 32'($signed($urandom_range(0, 33554432)) - 16777216);
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom();
      default: return small_coef();
    endcase
  endfunction

  function automatic logic [19:0] near_pixel(logic [19:0] c);
    int p;
    p = int'(c) + int'($urandom_range(0, 32768)) - 16384;
    if (p < 0) p = 0;
    if (p > 1048575) p = 1048575;
    return p[19:0];
  endfunction

  initial begin
    logic [19:0] cxv, cyv;
    logic [63:0] fx, fy;
    int mode;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // pass-through with reset settings
    send_point(20'h0, 20'h0, 1'b0);
    send_point(20'hFFFFF, 20'hFFFFF, 1'b1);
    send_point(20'hFFFFF, 20'h0, 1'b0);
    send_point(20'h0, 20'hFFFFF, 1'b1);
    send_point(20'hAAAAA, 20'h55555, 1'b0);

    // zero focal lengths, normalization saturates
    set_lens(64'h0, 64'h0, 64'h0, 32'h01000000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_point(20'h0, 20'h0, 1'b0);
    send_point(20'hFFFFF, 20'hFFFFF, 1'b1);
    send_point(20'h00010, 20'hFFFFF, 1'b0);

    // extreme registers, divergent iteration
    set_lens(64'hFFFFFF, 64'hFFFFFF, 64'hFF_FFFF_FFFF, 32'h7FFFFFFF, 32'h80000000,
             32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_point(20'h0, 20'h0, 1'b1);
    send_point(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_point(20'h0, 20'hFFFFF, 1'b0);
    set_lens(64'h1, 64'hFFFFFF, 64'h0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
             32'h7FFFFFFF, 32'h80000000);
    send_point(20'hFFFFF, 20'h0, 1'b1);
    send_point(20'h12345, 20'h6789A, 1'b0);

    // realistic lens, only tangential terms
    set_lens(64'd128000, 64'd128000, {24'b0, 20'd3840, 20'd5120}, 32'h0, 32'h0, 32'h0,
             32'h00100000, 32'hFFF00000);
    send_point(20'd5120, 20'd3840, 1'b0);
    send_point(20'd10240, 20'd7680, 1'b1);
    send_point(20'd0, 20'd0, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      mode = ph % 4;
      idle_on = (ph != 5);
      cxv = 20'($urandom());
      cyv = 20'($urandom());
      case (mode)
        0: begin
          fx = 64'($urandom_range(50000, 600000));
          fy = 64'($urandom_range(50000, 600000));
          cxv = 20'($urandom_range(0, 40000));
          cyv = 20'($urandom_range(0, 40000));
          set_lens(fx, fy, {24'b0, cyv, cxv}, small_coef(), small_coef(), small_coef(),
                   small_coef() >>> 3, small_coef() >>> 3);
        end
        1: begin
          fx = {40'b0, 24'($urandom())};
          fy = {40'b0, 24'($urandom())};
          set_lens(fx, fy, {$urandom(), $urandom()}, $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom());
        end
        2: begin
          fx = 64'($urandom_range(20000, 300000));
          fy = 64'($urandom_range(20000, 300000));
          set_lens(fx, fy, {24'b0, cyv, cxv}, pick_coef(), pick_coef(), pick_coef(),
                   pick_coef(), pick_coef());
        end
        default: begin
          fx = $urandom_range(1, 3) == 1 ? 64'hFFFFFF : 64'($urandom_range(1, 1000));
          fy = $urandom_range(1, 3) == 1 ? 64'h0 : 64'($urandom_range(1, 100000));
          set_lens(fx, fy, {24'b0, cyv, cxv}, pick_coef(), 32'h0, pick_coef(), 32'h0,
                   pick_coef());
        end
      endcase
      for (int n = 0; n < 60; n++) begin
        if (ph == 2 && n == 30) wait_drained();
        if (mode == 0 || mode == 2)
          send_point(near_pixel(cxv), near_pixel(cyv), 1'($urandom()));
        else send_point(20'($urandom()), 20'($urandom()), 1'($urandom()));
      end
    end

    // back to pass-through
    set_lens(64'd256, 64'd256, 64'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    for (int n = 0; n < 20; n++) send_point(20'($urandom()), 20'($urandom()), 1'($urandom()));

    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (800) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("lens_undistort_point_tb: clean");
    end else begin
      $display("lens_undistort_point_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
